/* sv/rsdz_pkg.sv */
// Shared constants for the radial stick dead zone block.
// No dependencies; imported by every module of the block.
package rsdz_pkg;

    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DZ_W = 15;
    localparam logic [DZ_W-1:0] DZ_RESET = 15'd4915;

endpackage

/* sv/rsdz_isqrt.sv */
// Pipelined integer square root, one root bit per stage, with a tag lane.
// Depends on rsdz_pkg.
module rsdz_isqrt import rsdz_pkg::*; #(
    parameter int R_W   = DEF_SAMPLE_WIDTH,
    parameter int TAG_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [TAG_W-1:0]    i_tag,
    input  logic [2*R_W-1:0]    i_sq,
    output logic                o_valid,
    output logic [TAG_W-1:0]    o_tag,
    output logic [R_W-1:0]      o_root
);

    localparam int S_W = 2 * R_W;

    logic               r_v    [0:R_W];
    logic [TAG_W-1:0]   r_t    [0:R_W];
    logic [S_W-1:0]     r_rem  [0:R_W];
    logic [R_W-1:0]     r_root [0:R_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0]    <= i_tag;
            r_rem[0]  <= i_sq;
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        localparam int B = R_W - 1 - k;
        logic [S_W:0] w_trial;
        logic         w_take;
        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        assign w_trial = ((S_W + 1)'(r_root[k]) << (B + 1)) | ((S_W + 1)'(1) << (2 * B));
        assign w_take  = {1'b0, r_rem[k]} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[k+1] <= r_t[k];
                if (w_take) begin
                    r_rem[k+1]  <= r_rem[k] - S_W'(w_trial);
                    r_root[k+1] <= r_root[k] | (R_W'(1) << B);
                end else begin
                    r_rem[k+1]  <= r_rem[k];
                    r_root[k+1] <= r_root[k];
                end
            end
        end
    end

    assign o_valid = r_v[R_W];
    assign o_tag   = r_t[R_W];
    assign o_root  = r_root[R_W];

endmodule

/* sv/rsdz_div.sv */
// Pipelined restoring divider, one quotient bit per stage, shared divisor over
// one or more lanes; saturates to all ones on overflow. Depends on rsdz_pkg.
module rsdz_div import rsdz_pkg::*; #(
    parameter int N_W   = 2 * DEF_SAMPLE_WIDTH,
    parameter int D_W   = DEF_SAMPLE_WIDTH,
    parameter int Q_W   = DEF_SAMPLE_WIDTH,
    parameter int LANES = 1,
    parameter int TAG_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [TAG_W-1:0]    i_tag,
    input  logic [N_W-1:0]      i_num [0:LANES-1],
    input  logic [D_W-1:0]      i_den,
    output logic                o_valid,
    output logic [TAG_W-1:0]    o_tag,
    output logic [Q_W-1:0]      o_quo [0:LANES-1]
);

    localparam int C_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic               r_v [0:Q_W];
    logic [TAG_W-1:0]   r_t [0:Q_W];
    logic [D_W-1:0]     r_d [0:Q_W];
    logic [C_W-1:0]     r_r [0:Q_W][0:LANES-1];
    logic [Q_W-1:0]     r_q [0:Q_W][0:LANES-1];
    logic               r_o [0:Q_W][0:LANES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0] <= i_tag;
            r_d[0] <= i_den;
            for (int l = 0; l < LANES; l++) begin
                r_r[0][l] <= C_W'(i_num[l]);
                r_q[0][l] <= '0;
                r_o[0][l] <= C_W'(i_num[l]) >= (C_W'(i_den) << Q_W);
            end
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [C_W-1:0] w_sub;
        assign w_sub = C_W'(r_d[k]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[k+1] <= r_t[k];
                r_d[k+1] <= r_d[k];
                for (int l = 0; l < LANES; l++) begin
                    r_o[k+1][l] <= r_o[k][l];
                    if (r_r[k][l] >= w_sub) begin
                        r_r[k+1][l] <= r_r[k][l] - w_sub;
                        r_q[k+1][l] <= r_q[k][l] | (Q_W'(1) << B);
                    end else begin
                        r_r[k+1][l] <= r_r[k][l];
                        r_q[k+1][l] <= r_q[k][l];
                    end
                end
            end
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_tag   = r_t[Q_W];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_o[Q_W][l] ? '1 : r_q[Q_W][l];
        end
    end

endmodule

/* sv/radial_stick_dead_zone.sv */
// Radial dead zone for one stick of a pad: picks a stick, gates on its
// magnitude and rescales both axes. Depends on rsdz_pkg, rsdz_isqrt, rsdz_div.
//
// One word is accepted every cycle unless a result waits at the output, and
// each word gives one result. Most of the pipeline is the bit-per-stage square
// root and the two bit-per-stage dividers. Six more register stages and the
// output register make up the rest. The whole pipeline advances together; it
// holds while a result waits at the output, without losing or repeating a
// word. The dead_zone register (Q0.15, reset 0.15) is written through the
// config channel, always ready, and is to be written while idle.
module radial_stick_dead_zone import rsdz_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_connected,
    input  logic                            i_side,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_left_x,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_left_y,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_right_x,
    input  logic signed [SAMPLE_WIDTH-1:0]  i_right_y,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]  o_out_x,
    output logic signed [SAMPLE_WIDTH-1:0]  o_out_y,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [DZ_W-1:0]                 i_cfg_data
);

    localparam int W = SAMPLE_WIDTH;
    localparam int F = W - 1;
    localparam logic [W-1:0] ONE = W'(1) << F;
    localparam int T1_W = 3 + 2 * W;
    localparam int T2_W = 3 + 3 * W;
    localparam int T3_W = 3;

    logic w_en;
    assign w_en        = !o_valid || i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    // dead zone register and derived constants
    logic [DZ_W-1:0] r_dz_raw;
    logic [W-1:0]    w_dz;
    logic [2*W-1:0]  r_dz_sq;
    logic [W-1:0]    w_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz_raw <= DZ_RESET;
        end else if (i_cfg_valid) begin
            r_dz_raw <= i_cfg_data;
        end
    end

    if (F >= DZ_W) begin : g_dz_up
        assign w_dz = W'(r_dz_raw) << (F - DZ_W);
    end else begin : g_dz_down
        assign w_dz = W'(r_dz_raw >> (DZ_W - F));
    end

    always_ff @(posedge i_clk) begin
        r_dz_sq <= w_dz * w_dz;
    end
    assign w_den = ONE - w_dz;

    // stage 1: stick select and magnitudes
    logic           r_s1_v, r_s1_conn, r_s1_sx, r_s1_sy;
    logic [W-1:0]   r_s1_ax, r_s1_ay;
    logic [W-1:0]   w_x, w_y;
    assign w_x = i_side ? i_right_x : i_left_x;
    assign w_y = i_side ? i_right_y : i_left_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_conn <= i_connected;
            r_s1_sx   <= w_x[W-1];
            r_s1_sy   <= w_y[W-1];
            r_s1_ax   <= w_x[W-1] ? (~w_x + W'(1)) : w_x;
            r_s1_ay   <= w_y[W-1] ? (~w_y + W'(1)) : w_y;
        end
    end

    // stage 2: squares
    logic           r_s2_v, r_s2_conn, r_s2_sx, r_s2_sy;
    logic [W-1:0]   r_s2_ax, r_s2_ay;
    logic [2*W-1:0] r_s2_px, r_s2_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_conn <= r_s1_conn;
            r_s2_sx   <= r_s1_sx;
            r_s2_sy   <= r_s1_sy;
            r_s2_ax   <= r_s1_ax;
            r_s2_ay   <= r_s1_ay;
            r_s2_px   <= r_s1_ax * r_s1_ax;
            r_s2_py   <= r_s1_ay * r_s1_ay;
        end
    end

    // stage 3: sum of squares and exact gate
    logic           r_s3_v, r_s3_live, r_s3_sx, r_s3_sy;
    logic [W-1:0]   r_s3_ax, r_s3_ay;
    logic [2*W-1:0] r_s3_sq;
    logic [2*W-1:0] w_sq;
    assign w_sq = r_s2_px + r_s2_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_en) begin
            r_s3_v <= r_s2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_live <= r_s2_conn && (w_sq > r_dz_sq);
            r_s3_sx   <= r_s2_sx;
            r_s3_sy   <= r_s2_sy;
            r_s3_ax   <= r_s2_ax;
            r_s3_ay   <= r_s2_ay;
            r_s3_sq   <= w_sq;
        end
    end

    // square root
    logic               w_s_v;
    logic [T1_W-1:0]    w_s_tag;
    logic [W-1:0]       w_m;

    rsdz_isqrt #(.R_W(W), .TAG_W(T1_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s3_v),
        .i_tag   ({r_s3_live, r_s3_sx, r_s3_sy, r_s3_ax, r_s3_ay}),
        .i_sq    (r_s3_sq),
        .o_valid (w_s_v),
        .o_tag   (w_s_tag),
        .o_root  (w_m)
    );

    // stage: numerator of the rescale
    logic               r_s4_v;
    logic [T2_W-1:0]    r_s4_tag;
    logic [W-1:0]       r_s4_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (w_en) begin
            r_s4_v <= w_s_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_tag <= {w_s_tag, w_m};
            r_s4_num <= (w_m > w_dz) ? (w_m - w_dz) : '0;
        end
    end

    // rescale divide: num * 2^F / (2^F - dz), spare quotient bit for the clamp
    logic [2*W-2:0]     w_d1_num [0:0];
    logic [2*W-2:0]     w_d1_den_dummy;
    logic               w_d1_v;
    logic [T2_W-1:0]    w_d1_tag;
    logic [W:0]         w_d1_q [0:0];
    assign w_d1_den_dummy = {r_s4_num, {F{1'b0}}};
    assign w_d1_num[0]    = w_d1_den_dummy;

    rsdz_div #(.N_W(2*W-1), .D_W(W), .Q_W(W+1), .LANES(1), .TAG_W(T2_W)) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s4_v),
        .i_tag   (r_s4_tag),
        .i_num   (w_d1_num),
        .i_den   (w_den),
        .o_valid (w_d1_v),
        .o_tag   (w_d1_tag),
        .o_quo   (w_d1_q)
    );

    // stage: clamp to 1.0
    logic               r_s5_v;
    logic [T2_W-1:0]    r_s5_tag;
    logic [W-1:0]       r_s5_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (w_en) begin
            r_s5_v <= w_d1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_tag    <= w_d1_tag;
            r_s5_scaled <= (w_d1_q[0] > (W + 1)'(ONE)) ? ONE : W'(w_d1_q[0]);
        end
    end

    // stage: axis times scale
    logic               r_s6_v, r_s6_live, r_s6_sx, r_s6_sy;
    logic [W-1:0]       r_s6_m;
    logic [2*W-1:0]     r_s6_prod [0:1];
    logic               w5_live, w5_sx, w5_sy;
    logic [W-1:0]       w5_ax, w5_ay, w5_m;
    assign {w5_live, w5_sx, w5_sy, w5_ax, w5_ay, w5_m} = r_s5_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else if (w_en) begin
            r_s6_v <= r_s5_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_live    <= w5_live;
            r_s6_sx      <= w5_sx;
            r_s6_sy      <= w5_sy;
            r_s6_m       <= w5_m;
            r_s6_prod[0] <= w5_ax * r_s5_scaled;
            r_s6_prod[1] <= w5_ay * r_s5_scaled;
        end
    end

    // per-axis divide by the magnitude
    logic               w_d2_v;
    logic [T3_W-1:0]    w_d2_tag;
    logic [W-1:0]       w_d2_q [0:1];

    rsdz_div #(.N_W(2*W), .D_W(W), .Q_W(W), .LANES(2), .TAG_W(T3_W)) u_div_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s6_v),
        .i_tag   ({r_s6_live, r_s6_sx, r_s6_sy}),
        .i_num   (r_s6_prod),
        .i_den   (r_s6_m),
        .o_valid (w_d2_v),
        .o_tag   (w_d2_tag),
        .o_quo   (w_d2_q)
    );

    // output stage: sign, saturation, zero when gated off
    logic           r_out_v, r_out_live;
    logic [W-1:0]   r_out_x, r_out_y;
    logic           w7_live, w7_sx, w7_sy;
    assign {w7_live, w7_sx, w7_sy} = w_d2_tag;

    function automatic logic [W-1:0] apply_sign(input logic neg, input logic [W-1:0] q);
        logic [W-1:0] mag;
        if (neg) begin
            mag = (q > ONE) ? ONE : q;
            return ~mag + W'(1);
        end
        mag = (q > ONE - W'(1)) ? (ONE - W'(1)) : q;
        return mag;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_d2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_live <= w7_live;
            r_out_x    <= w7_live ? apply_sign(w7_sx, w_d2_q[0]) : '0;
            r_out_y    <= w7_live ? apply_sign(w7_sy, w_d2_q[1]) : '0;
        end
    end

    assign o_valid = r_out_v;
    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;

`ifndef NO_ASSERTIONS
    // a word gated off by the dead zone or a missing pad leaves as zero
    a_gated_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_out_live) |-> (o_out_x == '0 && o_out_y == '0))
        else $error("gated word not zero");

    // the axis quotient never exceeds 1.0 since each axis is within the magnitude
    a_axis_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d2_v && w7_live) |-> (w_d2_q[0] <= ONE && w_d2_q[1] <= ONE))
        else $error("axis quotient above full scale");

    // a stalled pipeline holds its inner stages
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_s5_scaled) && $stable(r_s5_v) && $stable(r_s3_sq)))
        else $error("pipeline moved during stall");
`endif

endmodule

/* tb/tb_radial_stick_dead_zone.sv */
// Testbench for radial_stick_dead_zone: directed and random pad words checked
// against a bit-accurate predictor. Depends on rsdz_pkg and the block's RTL.
`timescale 1ns / 1ps

import rsdz_pkg::*;

class dead_zone_board;
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } axes_t;

    axes_t           pending[$];
    logic [DZ_W-1:0] dz_reg;
    int              mismatches;

    function new();
        dz_reg     = DZ_RESET;
        mismatches = 0;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function logic [15:0] rescale_axis(longint v, longint unsigned scaled,
                                       longint unsigned m);
        longint unsigned a;
        longint unsigned q;
        a = (v < 0) ? -v : v;
        q = (a * scaled) / m;
        if (v < 0) begin
            if (q > 32768) q = 32768;
            return 16'(-q);
        end
        if (q > 32767) q = 32767;
        return q[15:0];
    endfunction

    function void note_word(logic conn, logic side, logic signed [15:0] lx,
                            logic signed [15:0] ly, logic signed [15:0] rx,
                            logic signed [15:0] ry);
        axes_t           r;
        longint          x;
        longint          y;
        longint unsigned sq;
        longint unsigned dz;
        longint unsigned m;
        longint unsigned num;
        longint unsigned scaled;
        r.x = 0;
        r.y = 0;
        if (conn) begin
            x  = side ? rx : lx;
            y  = side ? ry : ly;
            sq = x * x + y * y;
            dz = dz_reg;
            if (sq > dz * dz) begin
                m      = root_floor(sq);
                num    = (m > dz) ? m - dz : 0;
                scaled = (num << 15) / (32768 - dz);
                if (scaled > 32768) scaled = 32768;
                if (m != 0) begin
                    r.x = rescale_axis(x, scaled, m);
                    r.y = rescale_axis(y, scaled, m);
                end
            end
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] ox, logic signed [15:0] oy);
        axes_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d %0d", ox, oy);
            return;
        end
        e = pending.pop_front();
        if (e.x !== ox || e.y !== oy) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp x=%0d y=%0d got x=%0d y=%0d",
                         e.x, e.y, ox, oy);
        end
    endfunction
endclass

module tb_radial_stick_dead_zone;
    localparam int LATENCY = 4 * DEF_SAMPLE_WIDTH + 10;
    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_connected;
    logic              i_side;
    logic signed [15:0] i_left_x;
    logic signed [15:0] i_left_y;
    logic signed [15:0] i_right_x;
    logic signed [15:0] i_right_y;
    logic              o_valid;
    logic              i_ready;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [DZ_W-1:0]   i_cfg_data;

    dead_zone_board board;
    int             cycles;
    bit             sink_on;

    radial_stick_dead_zone u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_connected(i_connected), .i_side(i_side),
        .i_left_x(i_left_x), .i_left_y(i_left_y),
        .i_right_x(i_right_x), .i_right_y(i_right_y),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_x(o_out_x), .o_out_y(o_out_y),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: sample at the edge, vary ready with random gaps.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) board.check_result(o_out_x, o_out_y);
    end

    initial begin : sink
        int g;
        i_ready = 1'b0;
        wait (sink_on);
        forever begin
            g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_word(logic conn, logic side, logic signed [15:0] lx,
                             logic signed [15:0] ly, logic signed [15:0] rx,
                             logic signed [15:0] ry, bit no_gap);
        int g;
        g = no_gap ? 0 : pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_connected <= conn;
        i_side      <= side;
        i_left_x    <= lx;
        i_left_y    <= ly;
        i_right_x   <= rx;
        i_right_y   <= ry;
        do @(posedge i_clk); while (!o_ready);
        board.note_word(conn, side, lx, ly, rx, ry);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_dead_zone(logic [DZ_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.dz_reg = v;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_words(int n);
        bit burst;
        repeat (n) begin
            burst = ($urandom_range(0, 4) == 0);
            send_word($urandom_range(0, 7) != 0, $urandom_range(0, 1),
                      rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                      burst);
        end
    endtask

    initial begin
        logic [DZ_W-1:0] dz_set [5] = '{15'd0, 15'd32767, 15'd1, 15'd16384, 15'd100};
        board       = new();
        cycles      = 0;
        sink_on     = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_connected = 1'b0;
        i_side      = 1'b0;
        i_left_x    = '0;
        i_left_y    = '0;
        i_right_x   = '0;
        i_right_y   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1;
        @(posedge i_clk);

        // Directed: reset dead zone, disconnected, corners, on and inside radius.
        send_word(0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_word(1, 0, 16'sh7fff, 16'sh7fff, 16'sh0, 16'sh0, 0);
        send_word(1, 1, 16'sh0, 16'sh0, 16'sh8000, 16'sh8000, 0);
        send_word(1, 0, 16'sh8000, 16'sh0, 16'sh0, 16'sh0, 1);
        send_word(1, 1, 16'sh0, 16'sh0, 16'sh0, 16'sh7fff, 1);
        send_word(1, 0, 16'sd4915, 16'sh0, 16'sh0, 16'sh0, 0);
        send_word(1, 0, 16'sd4916, 16'sh0, 16'sh0, 16'sh0, 0);
        send_word(1, 0, 16'sd3476, 16'sd3476, 16'sh0, 16'sh0, 0);
        send_word(1, 1, 16'sh0, 16'sh0, -16'sd3476, -16'sd3476, 0);
        send_word(1, 1, 16'sh0, 16'sh0, 16'sd4915, 16'sd1, 0);
        send_word(1, 0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 0);
        send_word(1, 0, -16'sd1, 16'sh7fff, 16'sh0, 16'sh0, 0);
        random_words(400);
        drain();

        foreach (dz_set[i]) begin
            write_dead_zone(dz_set[i]);
            send_word(1, 0, 16'sh8000, 16'sh8000, 16'sh0, 16'sh0, 0);
            send_word(1, 1, 16'sh0, 16'sh0, 16'sh7fff, -16'sd1, 0);
            send_word(1, 0, 16'(dz_set[i]), 16'sh0, 16'sh0, 16'sh0, 0);
            send_word(1, 0, 16'(dz_set[i] + 1), 16'sh0, 16'sh0, 16'sh0, 0);
            random_words(240);
            drain();
        end

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
